// ===== rtl/mps_pkg.sv =====
// Shared types, constants and the bin average helper for the measurement sequencer.
`timescale 1ns / 1ps

package mps_pkg;

  // Field widths
  localparam int SAMPLE_W    = 12;
  localparam int TICK_W      = 32;
  localparam int PH_TIME_W   = 24;
  localparam int SUB_W       = 16;
  localparam int DEB_W       = 8;
  localparam int AVG_W       = 16;
  localparam int BIN_CNT_W   = 6;
  localparam int SUM_W       = 18;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Subsamples per bin (1..63)
  localparam int SAMPLES_PER_BIN = 50;

  // Register reset values
  localparam logic [PH_TIME_W-1:0] SETTLE_RST    = PH_TIME_W'(30000);
  localparam logic [PH_TIME_W-1:0] MEASURE_RST   = PH_TIME_W'(30000);
  localparam logic [SUB_W-1:0]     SUBSAMPLE_RST = SUB_W'(100);
  localparam logic [DEB_W-1:0]     DEBOUNCE_RST  = DEB_W'(30);

  // Reciprocal for floor(sum * 16 / SAMPLES_PER_BIN).
  // Ceiling reciprocal is exact while x * err < 2^DIV_K, x < 2^(SUM_W+4), err < 2^BIN_CNT_W.
  localparam int DIV_K   = SUM_W + 4 + BIN_CNT_W + 1;
  localparam int RECIP_W = DIV_K + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_K) + 64'(SAMPLES_PER_BIN) - 64'd1) / 64'(SAMPLES_PER_BIN));
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int AVG_SHIFT = DIV_K - 4;

  typedef enum logic [2:0] {
    STG_IDLE       = 3'd0,
    STG_DARK_FIRST = 3'd1,
    STG_REFERENCE  = 3'd2,
    STG_SAMPLE     = 3'd3,
    STG_DARK_LAST  = 3'd4,
    STG_DONE       = 3'd5
  } step_t;

  typedef enum logic [1:0] {
    PH_PROMPT  = 2'd0,
    PH_SETTLE  = 2'd1,
    PH_MEASURE = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE    = 3'd0,
    CFG_MEASURE   = 3'd1,
    CFG_SUBSAMPLE = 3'd2,
    CFG_DEBOUNCE  = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PH_TIME_W-1:0] settle_ticks;
    logic [PH_TIME_W-1:0] measure_ticks;
    logic [SUB_W-1:0]     subsample_ticks;
    logic [DEB_W-1:0]     debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic                button_level;
    logic [SAMPLE_W-1:0] detector_sample;
  } mps_in_t;

  typedef struct packed {
    step_t                step_now;
    phase_t               phase_now;
    logic                 row_valid;
    logic [AVG_W-1:0]     bin_average;
    logic [TICK_W-1:0]    time_since_reset;
    logic [PH_TIME_W-1:0] time_in_phase;
    logic [BIN_CNT_W-1:0] samples_in_bin;
    logic                 press_accepted;
  } mps_out_t;

  // 12.4 average of a full bin, truncated, clamped to 16 bits
  function automatic logic [AVG_W-1:0] bin_avg(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quo;
    prod = PROD_W'(sum) * PROD_W'(RECIP);
    quo  = prod >> AVG_SHIFT;
    if (|quo[PROD_W-1:AVG_W]) begin
      bin_avg = '1;
    end else begin
      bin_avg = quo[AVG_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/mps_cfg.sv =====
// Configuration register file of the measurement sequencer.
`timescale 1ns / 1ps

module mps_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_data,
  output mps_pkg::cfg_t                  cfg
);
  import mps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks    <= SETTLE_RST;
      cfg.measure_ticks   <= MEASURE_RST;
      cfg.subsample_ticks <= SUBSAMPLE_RST;
      cfg.debounce_ticks  <= DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE:    cfg.settle_ticks    <= cfg_data[PH_TIME_W-1:0];
        CFG_MEASURE:   cfg.measure_ticks   <= cfg_data[PH_TIME_W-1:0];
        CFG_SUBSAMPLE: cfg.subsample_ticks <= cfg_data[SUB_W-1:0];
        CFG_DEBOUNCE:  cfg.debounce_ticks  <= cfg_data[DEB_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

endmodule

// ===== rtl/mps_seq.sv =====
// Per-tick sequencer: debounce, step/phase control, subsampling, bin averaging.
`timescale 1ns / 1ps

module mps_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  mps_pkg::mps_in_t   in_data,
  input  mps_pkg::cfg_t      cfg,
  output mps_pkg::mps_out_t  res
);
  import mps_pkg::*;

  step_t                step;
  phase_t               phase;
  logic [TICK_W-1:0]    tick_count;
  logic [PH_TIME_W-1:0] phase_elapsed;
  logic [SUB_W-1:0]     countdown;
  logic [BIN_CNT_W-1:0] bin_count;
  logic [SUM_W-1:0]     bin_sum;
  logic                 button_stable;
  logic [DEB_W-1:0]     since_change;

  step_t                step_next;
  phase_t               phase_next;
  logic [PH_TIME_W-1:0] phase_elapsed_next;
  logic [SUB_W-1:0]     countdown_next;
  logic [BIN_CNT_W-1:0] bin_count_next;
  logic [SUM_W-1:0]     bin_sum_next;
  logic                 button_stable_next;
  logic [DEB_W-1:0]     since_change_next;

  always_comb begin
    logic pressed;
    logic row;
    logic [AVG_W-1:0] avg;

    step_next          = step;
    phase_next         = phase;
    phase_elapsed_next = phase_elapsed;
    countdown_next     = countdown;
    bin_count_next     = bin_count;
    bin_sum_next       = bin_sum;
    button_stable_next = button_stable;
    since_change_next  = since_change;
    pressed            = 1'b0;
    row                = 1'b0;
    avg                = '0;

    // debounce; a press only moves the sequence from a prompt
    if ((in_data.button_level != button_stable) && (since_change > cfg.debounce_ticks)) begin
      button_stable_next = in_data.button_level;
      since_change_next  = '0;
      if (!in_data.button_level) begin
        pressed = 1'b1;
        if (phase == PH_PROMPT) begin
          if (step == STG_DONE) begin
            step_next = STG_IDLE;
          end else begin
            if (step == STG_IDLE) begin
              step_next = STG_DARK_FIRST;
            end
            phase_next         = PH_SETTLE;
            phase_elapsed_next = '0;
            bin_count_next     = '0;
            bin_sum_next       = '0;
            countdown_next     = '0;
          end
        end
      end
    end

    // subsample into the bin
    if (((phase_next == PH_SETTLE) || (phase_next == PH_MEASURE)) && (countdown_next == '0)) begin
      bin_sum_next   = bin_sum_next + SUM_W'(in_data.detector_sample);
      bin_count_next = bin_count_next + BIN_CNT_W'(1);
      countdown_next = cfg.subsample_ticks;
      if (bin_count_next >= BIN_CNT_W'(SAMPLES_PER_BIN)) begin
        row            = 1'b1;
        avg            = bin_avg(bin_sum_next);
        bin_count_next = '0;
        bin_sum_next   = '0;
      end
    end

    res.step_now         = step_next;
    res.phase_now        = phase_next;
    res.row_valid        = row;
    res.bin_average      = avg;
    res.time_since_reset = tick_count;
    res.time_in_phase    = phase_elapsed_next;
    res.samples_in_bin   = bin_count_next;
    res.press_accepted   = pressed;

    // phase timer; takes effect from the next tick
    if ((phase_next == PH_SETTLE) && (phase_elapsed_next >= cfg.settle_ticks)) begin
      phase_next         = PH_MEASURE;
      phase_elapsed_next = '0;
      bin_count_next     = '0;
      bin_sum_next       = '0;
      countdown_next     = '0;
    end else if ((phase_next == PH_MEASURE) && (phase_elapsed_next >= cfg.measure_ticks)) begin
      if (step_next inside {[STG_DARK_FIRST:STG_DARK_LAST]}) begin
        step_next = step_t'(step_next + 3'd1);
      end else begin
        step_next = STG_IDLE;
      end
      phase_next = PH_PROMPT;
    end

    // end-of-tick counters
    if (phase_elapsed_next != '1) begin
      phase_elapsed_next = phase_elapsed_next + PH_TIME_W'(1);
    end
    if (countdown_next != '0) begin
      countdown_next = countdown_next - SUB_W'(1);
    end
    if (since_change_next != '1) begin
      since_change_next = since_change_next + DEB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STG_IDLE;
      phase         <= PH_PROMPT;
      tick_count    <= '0;
      phase_elapsed <= '0;
      countdown     <= '0;
      bin_count     <= '0;
      bin_sum       <= '0;
      button_stable <= 1'b1;
      since_change  <= '0;
    end else if (accept) begin
      step          <= step_next;
      phase         <= phase_next;
      tick_count    <= tick_count + TICK_W'(1);
      phase_elapsed <= phase_elapsed_next;
      countdown     <= countdown_next;
      bin_count     <= bin_count_next;
      bin_sum       <= bin_sum_next;
      button_stable <= button_stable_next;
      since_change  <= since_change_next;
    end
  end

`ifndef SYNTHESIS
  a_row_clears_bin: assert property (@(posedge clk) disable iff (rst)
    (accept && res.row_valid) |=> (bin_count == '0))
    else $error("bin not cleared after a completed row");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    accept |=> (tick_count == $past(tick_count) + TICK_W'(1)))
    else $error("tick counter did not advance on an accepted beat");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(step) && $stable(phase) && $stable(bin_sum)))
    else $error("sequencer state moved without an input beat");
`endif

endmodule

// ===== rtl/mps_obuf.sv =====
// Two-entry output buffer (main register plus skid) for result beats.
`timescale 1ns / 1ps

module mps_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mps_pkg::mps_out_t din,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output mps_pkg::mps_out_t dout
);
  import mps_pkg::*;

  logic     main_valid;
  logic     skid_valid;
  mps_out_t main_data;
  mps_out_t skid_data;
  logic     pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign dout      = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= din;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= din;
      end else begin
        main_data <= din;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without a main entry");
`endif

endmodule

// ===== rtl/measurement_protocol_sequencer_core.sv =====
// Top level of the measurement protocol sequencer.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one beat per millisecond tick,
//    carrying the raw button level and the current 12-bit detector sample.
//  - Output channel (out_valid/out_ready/out_data): exactly one result beat per
//    input beat, in order: step, phase, bin row flag and 12.4 average,
//    timestamps, bin fill and press flag.
//  - Config port (cfg_we/cfg_index/cfg_data): single-cycle writes of settle,
//    measure, subsample and debounce periods; change them only while idle.
// A result is registered in the output buffer before it appears on out_valid.
// Throughput: one beat per cycle while in_ready is high; the whole tick update
//   is one pass of counters, compares, an 18-bit add and a constant-reciprocal
//   multiply between the sequencer state registers and the output buffer.
// Stalls: results land in a two-entry buffer; in_ready drops only when both
//   entries are full, and returns the cycle after the receiver takes a beat.
// Reset (rst, synchronous): idle step at the prompt, all counters zero, the
//   button taken as released, config registers back to their defaults, and
//   the output buffer emptied.
`timescale 1ns / 1ps

module measurement_protocol_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mps_pkg::mps_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mps_pkg::mps_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mps_pkg::*;

  cfg_t     cfg;
  mps_out_t res;
  logic     accept;

  // a beat is taken whenever one is offered and the output buffer has a free entry
  assign accept = in_valid && in_ready;

  mps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state update and result for the accepted tick
  mps_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  mps_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (out_data)
  );

endmodule

// ===== verif/tb_measurement_protocol_sequencer_core.sv =====
// Self-checking testbench for the measurement protocol sequencer core.
`timescale 1ns / 1ps

module tb_measurement_protocol_sequencer_core;
  import mps_pkg::*;

  // Run limits
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 190;

  // Index past the last register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  mps_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mps_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  measurement_protocol_sequencer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Directed table. Rows with pinned set carry a hand-written result (state
  // right after reset, first press with the sample at full scale); the rest
  // are checked against the sequencer model like the random beats.
  // Config for this table: settle 0, measure 2, subsample 0, debounce 0.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                lvl;
    logic [SAMPLE_W-1:0] smp;
    logic                pinned;
    mps_out_t            want;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset state, button released
    '{1'b1, 12'h000, 1'b1,
      '{STG_IDLE, PH_PROMPT, 1'b0, 16'd0, 32'd0, 24'd0, 6'd0, 1'b0}},
    // first press: dark pre, settle entered, subsample due at once
    '{1'b0, 12'hFFF, 1'b1,
      '{STG_DARK_FIRST, PH_SETTLE, 1'b0, 16'd0, 32'd1, 24'd0, 6'd1, 1'b1}},
    '{1'b1, 12'hFFF, 1'b0, '0},  // release while measuring
    '{1'b0, 12'h000, 1'b0, '0},  // press outside the prompt: flag only
    '{1'b1, 12'hAAA, 1'b0, '0},  // measure timeout -> reference prompt
    '{1'b0, 12'h555, 1'b0, '0},
    '{1'b1, 12'h7FF, 1'b0, '0},
    '{1'b1, 12'h800, 1'b0, '0},
    '{1'b1, 12'h001, 1'b0, '0},
    '{1'b0, 12'h0F0, 1'b0, '0},
    '{1'b1, 12'hF0F, 1'b0, '0},
    '{1'b1, 12'h333, 1'b0, '0},
    '{1'b1, 12'hCCC, 1'b0, '0},
    '{1'b0, 12'h123, 1'b0, '0},
    '{1'b1, 12'hEDC, 1'b0, '0},
    '{1'b1, 12'h456, 1'b0, '0},
    '{1'b1, 12'hBA9, 1'b0, '0},  // dark post ends -> done
    '{1'b0, 12'hFFF, 1'b0, '0},  // press at done -> idle prompt
    '{1'b1, 12'h000, 1'b0, '0},
    '{1'b0, 12'h0FF, 1'b0, '0},  // press from idle starts again
    '{1'b1, 12'hF00, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Sequencer model: own copy of config and state, stepped once per accepted
  // input beat.
  // ---------------------------------------------------------------------------
  cfg_t                 cfg_model;
  step_t                seq_step;
  phase_t               seq_phase;
  logic [TICK_W-1:0]    seq_ticks;
  logic [PH_TIME_W-1:0] seq_elapsed;
  logic [SUB_W-1:0]     seq_sub_wait;
  logic [BIN_CNT_W-1:0] seq_bin_cnt;
  logic [SUM_W-1:0]     seq_bin_sum;
  logic                 seq_btn;
  logic [DEB_W-1:0]     seq_since_chg;

  mps_out_t expected_rows[$];

  int sent;
  int results_seen;
  int mismatches;

  function automatic void restart_phase(input phase_t ph);
    seq_phase    = ph;
    seq_elapsed  = '0;
    seq_bin_cnt  = '0;
    seq_bin_sum  = '0;
    seq_sub_wait = '0;
  endfunction

  function automatic mps_out_t advance_sequencer(input mps_in_t beat);
    mps_out_t r;
    int       avg;
    r = '0;

    // debounce; only a falling edge counts as a press
    if (beat.button_level != seq_btn && seq_since_chg > cfg_model.debounce_ticks) begin
      seq_btn       = beat.button_level;
      seq_since_chg = '0;
      if (!beat.button_level) begin
        r.press_accepted = 1'b1;
        if (seq_phase == PH_PROMPT) begin
          if (seq_step == STG_DONE) begin
            seq_step = STG_IDLE;
          end else begin
            if (seq_step == STG_IDLE) seq_step = STG_DARK_FIRST;
            restart_phase(PH_SETTLE);
          end
        end
      end
    end

    // subsample into the bin
    if ((seq_phase == PH_SETTLE || seq_phase == PH_MEASURE) && seq_sub_wait == '0) begin
      seq_bin_sum  = seq_bin_sum + SUM_W'(beat.detector_sample);
      seq_bin_cnt  = seq_bin_cnt + 1'b1;
      seq_sub_wait = cfg_model.subsample_ticks;
      if (int'(seq_bin_cnt) >= SAMPLES_PER_BIN) begin
        avg = (int'(seq_bin_sum) * 16) / SAMPLES_PER_BIN;
        if (avg > 65535) avg = 65535;
        r.row_valid   = 1'b1;
        r.bin_average = AVG_W'(avg);
        seq_bin_cnt   = '0;
        seq_bin_sum   = '0;
      end
    end

    r.step_now         = seq_step;
    r.phase_now        = seq_phase;
    r.time_since_reset = seq_ticks;
    r.time_in_phase    = seq_elapsed;
    r.samples_in_bin   = seq_bin_cnt;

    // phase timer; takes effect from the next tick
    if (seq_phase == PH_SETTLE && seq_elapsed >= cfg_model.settle_ticks) begin
      restart_phase(PH_MEASURE);
    end else if (seq_phase == PH_MEASURE && seq_elapsed >= cfg_model.measure_ticks) begin
      if (seq_step >= STG_DARK_FIRST && seq_step <= STG_DARK_LAST) begin
        seq_step = step_t'(seq_step + 3'd1);
      end else begin
        seq_step = STG_IDLE;
      end
      seq_phase = PH_PROMPT;
    end

    seq_ticks = seq_ticks + 1'b1;
    if (seq_elapsed != '1) seq_elapsed = seq_elapsed + 1'b1;
    if (seq_sub_wait != '0) seq_sub_wait = seq_sub_wait - 1'b1;
    if (seq_since_chg != '1) seq_since_chg = seq_since_chg + 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Button waveform for the random part: alternating press/release holds
  // long enough to pass the debounce, with contact bounce right after each
  // flip and a little stray noise.
  // ---------------------------------------------------------------------------
  logic btn_lvl  = 1'b1;
  int   btn_hold = 5;
  int   btn_age  = 0;

  function automatic logic next_button();
    logic lvl;
    if (btn_hold == 0) begin
      btn_lvl  = ~btn_lvl;
      btn_hold = int'(cfg_model.debounce_ticks) + int'($urandom_range(2, 40));
      btn_age  = 0;
    end else begin
      btn_hold--;
    end
    lvl = btn_lvl;
    if (btn_age < 4 && $urandom_range(0, 99) < 30) begin
      lvl = ~lvl;  // bounce
    end else if ($urandom_range(0, 99) < 3) begin
      lvl = ~lvl;  // stray glitch
    end
    btn_age++;
    return lvl;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("beat %0d %s: got 0x%0h, want 0x%0h", results_seen, what, got, want);
  endtask

  task automatic compare_row(input mps_out_t want, input mps_out_t got);
    if (got.step_now != want.step_now)
      report_mismatch("step_now", got.step_now, want.step_now);
    if (got.phase_now != want.phase_now)
      report_mismatch("phase_now", got.phase_now, want.phase_now);
    if (got.row_valid != want.row_valid)
      report_mismatch("row_valid", got.row_valid, want.row_valid);
    if (got.bin_average != want.bin_average)
      report_mismatch("bin_average", got.bin_average, want.bin_average);
    if (got.time_since_reset != want.time_since_reset)
      report_mismatch("time_since_reset", got.time_since_reset, want.time_since_reset);
    if (got.time_in_phase != want.time_in_phase)
      report_mismatch("time_in_phase", got.time_in_phase, want.time_in_phase);
    if (got.samples_in_bin != want.samples_in_bin)
      report_mismatch("samples_in_bin", got.samples_in_bin, want.samples_in_bin);
    if (got.press_accepted != want.press_accepted)
      report_mismatch("press_accepted", got.press_accepted, want.press_accepted);
  endtask

  // Output monitor: signals are read right after the edge, i.e. the values
  // the DUT saw at that edge.
  always @(posedge clk) begin : result_monitor
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("beat with nothing expected", out_data.time_since_reset, 0);
      end else begin
        compare_row(expected_rows.pop_front(), out_data);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls about a quarter of the time, a calm window with
  // none, and two long hold-offs that fill the output buffer and push back
  // on the input side.
  // ---------------------------------------------------------------------------
  int ready_cycles = 0;
  int hold_left    = 0;

  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      ready_cycles <= ready_cycles + 1;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (ready_cycles == 500 || ready_cycles == 2500) begin
        out_ready <= 1'b0;
        hold_left <= 60;
      end else if (ready_cycles >= 1200 && ready_cycles < 1600) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Watchdog
  int cycles = 0;

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one tick, with an optional random gap first. Valid stays up after
  // acceptance so back-to-back beats never drop it within a time step.
  task automatic offer_tick(input mps_in_t beat);
    int gap;
    if (!(sent >= 700 && sent < 900) && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    expected_rows.push_back(advance_sequencer(beat));
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SETTLE:    cfg_model.settle_ticks    = val;
      CFG_MEASURE:   cfg_model.measure_ticks   = val;
      CFG_SUBSAMPLE: cfg_model.subsample_ticks = val[SUB_W-1:0];
      CFG_DEBOUNCE:  cfg_model.debounce_ticks  = val[DEB_W-1:0];
      default: ;
    endcase
  endtask

  // Stop offering and let every expected beat come back, then wait a short
  // tail before touching the registers.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin : stimulus
    mps_in_t              beat;
    logic [PH_TIME_W-1:0] st;
    logic [PH_TIME_W-1:0] mt;
    logic [SUB_W-1:0]     sb;
    logic [DEB_W-1:0]     db;
    int                   pick;

    cfg_model     = '{SETTLE_RST, MEASURE_RST, SUBSAMPLE_RST, DEBOUNCE_RST};
    seq_step      = STG_IDLE;
    seq_phase     = PH_PROMPT;
    seq_ticks     = '0;
    seq_elapsed   = '0;
    seq_sub_wait  = '0;
    seq_bin_cnt   = '0;
    seq_bin_sum   = '0;
    seq_btn       = 1'b1;
    seq_since_chg = '0;
    sent          = 0;
    results_seen  = 0;
    mismatches    = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Upper data bits on the narrow registers must be dropped.
    write_reg(CFG_SETTLE, 24'd0);
    write_reg(CFG_MEASURE, 24'd2);
    write_reg(CFG_SUBSAMPLE, 24'hFF0000);
    write_reg(CFG_DEBOUNCE, 24'h123400);
    cfg_we <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      beat.button_level    = DIRECTED[i].lvl;
      beat.detector_sample = DIRECTED[i].smp;
      offer_tick(beat);
      if (DIRECTED[i].pinned) begin
        void'(expected_rows.pop_back());
        expected_rows.push_back(DIRECTED[i].want);
      end
    end

    // Random part: several register settings, state carried across them.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin st = 24'd40; mt = 24'd120; sb = 16'd0; db = 8'd0; end
        1: begin st = 24'd0;  mt = 24'd120; sb = 16'd1; db = 8'd3; end
        // everything at the top: timers never expire, presses never pass
        2: begin st = '1; mt = '1; sb = '1; db = '1; end
        3: begin st = 24'd1;  mt = 24'd0;   sb = 16'd0; db = 8'd254; end
        default: begin
          st = PH_TIME_W'($urandom_range(0, 60));
          mt = PH_TIME_W'($urandom_range(60, 200));
          sb = SUB_W'($urandom_range(0, 2));
          db = DEB_W'($urandom_range(0, 12));
        end
      endcase
      write_reg(CFG_SETTLE, st);
      write_reg(CFG_MEASURE, mt);
      write_reg(CFG_SUBSAMPLE, {8'($urandom), sb});
      write_reg(CFG_DEBOUNCE, {16'($urandom), db});
      write_reg(CFG_UNUSED_IDX, 24'($urandom));
      cfg_we <= 1'b0;

      for (int k = 0; k < PHASE_BEATS; k++) begin
        beat.button_level = next_button();
        case (p % 3)
          0: beat.detector_sample = SAMPLE_W'($urandom_range(0, 4095));
          1: beat.detector_sample = '1;  // full-scale bins
          default: begin
            pick = $urandom_range(0, 9);
            if (pick < 2)      beat.detector_sample = '0;
            else if (pick < 4) beat.detector_sample = '1;
            else               beat.detector_sample = SAMPLE_W'($urandom);
          end
        endcase
        offer_tick(beat);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== measurement_protocol_sequencer_core.f =====
rtl/mps_pkg.sv
rtl/mps_cfg.sv
rtl/mps_seq.sv
rtl/mps_obuf.sv
rtl/measurement_protocol_sequencer_core.sv
verif/tb_measurement_protocol_sequencer_core.sv
